### sv/nnis_pkg.sv
// Shared types and constants of the nearest-neighbor image scaler.
// Used by nearest_neighbor_image_scaler_unit; depends on nothing.
package nnis_pkg;

  localparam int unsigned SRC_DIM_MAX_DEF = 256;
  localparam int unsigned DST_DIM_MAX_DEF = 1024;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned SRC_REG_W  = 9;
  localparam int unsigned DST_REG_W  = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_DST_W = 2'd2,
    CFG_DST_H = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_XSTART,
    S_DIVX,
    S_DIVY,
    S_ADDR,
    S_READ,
    S_DONE
  } state_e;

endpackage

### sv/nearest_neighbor_image_scaler_unit.sv
// Nearest-neighbor image scaler: frame store, sequencer and output register.
// Depends on nnis_pkg and nnis_div.
//
// A load beat (tuser 0) writes tdata into the frame store at the next raster position of the
// source image, wrapping after width times height pixels. An emit beat (tuser 1) produces
// the next output pixel in raster order, copied from source column floor(x*sw/tw) and row
// floor(y*sh/th), with tlast on the last pixel of the output frame. Both coordinates come
// from one shared divider that yields one quotient bit per cycle. The input is not ready while
// a beat is processed. A finished pixel waits in an output register, and the next input beat
// is taken meanwhile. Reading a store entry that was never loaded returns an undefined pixel.
// Dimension registers of 0 act as 1 and values above the maximum act as the maximum.
module nearest_neighbor_image_scaler_unit #(
  parameter int unsigned SRC_DIM_MAX = nnis_pkg::SRC_DIM_MAX_DEF,
  parameter int unsigned DST_DIM_MAX = nnis_pkg::DST_DIM_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [nnis_pkg::PIXEL_W-1:0]    s_axis_tdata,   // [31:0] pixel_in
  input  logic                            s_axis_tuser,   // [0] operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [nnis_pkg::PIXEL_W-1:0]    m_axis_tdata,   // [31:0] pixel_out
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import nnis_pkg::*;

  localparam int unsigned SW_W        = $clog2(SRC_DIM_MAX + 1);
  localparam int unsigned DW          = $clog2(DST_DIM_MAX + 1);
  localparam int unsigned CNT_W       = $clog2(DST_DIM_MAX);
  localparam int unsigned STORE_DEPTH = SRC_DIM_MAX * SRC_DIM_MAX;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned AREA_W      = 2 * SW_W;
  localparam int unsigned PW          = CNT_W + SW_W;

  state_e state_q, state_d;

  logic [SRC_REG_W-1:0] src_w_q, src_h_q;
  logic [DST_REG_W-1:0] dst_w_q, dst_h_q;
  logic [SW_W-1:0]      sw_c, sh_c;
  logic [DW-1:0]        tw_c, th_c;

  logic [ADDR_W-1:0]    load_pos_q;
  logic [CNT_W-1:0]     col_q, row_q;
  logic [AREA_W-1:0]    area_q;
  logic [AREA_W-1:0]    pos_eff, pos_next;
  logic                 col_end, row_end;

  op_e                  op_q;
  logic [PIXEL_W-1:0]   pixel_q;
  logic [SW_W-1:0]      sx_q, sy_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 last_q;
  logic [PIXEL_W-1:0]   rdata_q;
  logic [PIXEL_W-1:0]   out_data_q;
  logic                 out_last_q;
  logic                 out_valid_q;

  logic                 div_start;
  logic [PW-1:0]        div_dividend;
  logic [PW-1:0]        div_divisor;
  logic                 div_done;
  logic [SW_W-1:0]      div_quot;

  logic                 mem_we;
  logic                 mem_re;
  logic                 out_load;

  logic [PIXEL_W-1:0]   store_mem [STORE_DEPTH];

  // Effective dimensions after clamping to 1..maximum.
  always_comb begin
    if (src_w_q == '0) begin
      sw_c = SW_W'(1);
    end else if (32'(src_w_q) > 32'(SRC_DIM_MAX)) begin
      sw_c = SW_W'(SRC_DIM_MAX);
    end else begin
      sw_c = SW_W'(src_w_q);
    end
    if (src_h_q == '0) begin
      sh_c = SW_W'(1);
    end else if (32'(src_h_q) > 32'(SRC_DIM_MAX)) begin
      sh_c = SW_W'(SRC_DIM_MAX);
    end else begin
      sh_c = SW_W'(src_h_q);
    end
    if (dst_w_q == '0) begin
      tw_c = DW'(1);
    end else if (32'(dst_w_q) > 32'(DST_DIM_MAX)) begin
      tw_c = DW'(DST_DIM_MAX);
    end else begin
      tw_c = DW'(dst_w_q);
    end
    if (dst_h_q == '0) begin
      th_c = DW'(1);
    end else if (32'(dst_h_q) > 32'(DST_DIM_MAX)) begin
      th_c = DW'(DST_DIM_MAX);
    end else begin
      th_c = DW'(dst_h_q);
    end
  end

  assign pos_eff  = (AREA_W'(load_pos_q) >= area_q) ? '0 : AREA_W'(load_pos_q);
  assign pos_next = ((pos_eff + AREA_W'(1)) >= area_q) ? '0 : (pos_eff + AREA_W'(1));
  assign col_end  = (DW'(col_q) == (tw_c - DW'(1)));
  assign row_end  = (DW'(row_q) == (th_c - DW'(1)));

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Sequencer: next state and strobes.
  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = PW'(col_q) * PW'(sw_c);
    div_divisor  = PW'(tw_c);
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = (op_q == OP_LOAD) ? S_LOAD : S_XSTART;
      end
      S_LOAD: begin
        mem_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_XSTART: begin
        div_start = 1'b1;
        state_d   = S_DIVX;
      end
      S_DIVX: begin
        div_dividend = PW'(row_q) * PW'(sh_c);
        div_divisor  = PW'(th_c);
        if (div_done) begin
          div_start = 1'b1;
          state_d   = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        state_d = S_READ;
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      src_w_q     <= SRC_REG_W'(1);
      src_h_q     <= SRC_REG_W'(1);
      dst_w_q     <= DST_REG_W'(1);
      dst_h_q     <= DST_REG_W'(1);
      load_pos_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SRC_W: src_w_q <= SRC_REG_W'(cfg_data_i);
          CFG_SRC_H: src_h_q <= SRC_REG_W'(cfg_data_i);
          CFG_DST_W: dst_w_q <= cfg_data_i;
          CFG_DST_H: dst_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_PREP && op_q == OP_EMIT) begin
        if (DW'(col_q) >= tw_c) begin
          col_q <= '0;
        end
        if (DW'(row_q) >= th_c) begin
          row_q <= '0;
        end
      end
      if (state_q == S_LOAD) begin
        load_pos_q <= ADDR_W'(pos_next);
      end
      if (state_q == S_ADDR) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_end ? '0 : (row_q + CNT_W'(1));
        end else begin
          col_q <= col_q + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= op_e'(s_axis_tuser);
      pixel_q <= s_axis_tdata;
    end
    if (state_q == S_PREP) begin
      area_q <= AREA_W'(sw_c) * AREA_W'(sh_c);
    end
    if (state_q == S_DIVX && div_done) begin
      sx_q <= div_quot;
    end
    if (state_q == S_DIVY && div_done) begin
      sy_q <= div_quot;
    end
    if (state_q == S_ADDR) begin
      addr_q <= ADDR_W'(AREA_W'(sy_q) * AREA_W'(sw_c) + AREA_W'(sx_q));
      last_q <= col_end && row_end;
    end
    if (out_load) begin
      out_data_q <= rdata_q;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[ADDR_W'(pos_eff)] <= pixel_q;
    end
    if (mem_re) begin
      rdata_q <= store_mem[addr_q];
    end
  end

  nnis_div #(
    .PW (PW),
    .QW (SW_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  a_load_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == S_LOAD) |-> (AREA_W'(load_pos_q) < area_q))
    else $error("load position left the source frame");

  a_addr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (AREA_W'(addr_q) < area_q))
    else $error("read address outside the loaded source frame");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ((DW'(col_q) < tw_c) && (DW'(row_q) < th_c)))
    else $error("output position outside the target frame");

  a_div_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == S_DIVX) || (state_q == S_DIVY)))
    else $error("divider finished outside a division step");

endmodule

### sv/nnis_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by both axes.
// Standalone; instantiated by nearest_neighbor_image_scaler_unit.
module nnis_div #(
  parameter int unsigned PW = 19,
  parameter int unsigned QW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] dividend_i,
  input  logic [PW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(QW);

  logic [PW-1:0] rem_q;
  logic [PW-1:0] dsh_q;
  logic [QW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;
  logic          ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(QW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= divisor_i << (QW - 1);
      quo_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
